// File: design/udrb_pkg.sv
// udrb_pkg: shared types and constants for the dual uart ring buffer
// depends on nothing; used by uart_dual_ring_buffer
`default_nettype none

package udrb_pkg;

   // ring geometry, fixed by the 4-bit level fields of the result
   localparam int RING_DEPTH = 8;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int LVL_W      = 4;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [LVL_W-1:0] lvl_type;
   typedef logic [7:0]       byte_type;

   localparam ptr_type PTR_LAST  = PTR_W'(RING_DEPTH - 1);
   localparam lvl_type RING_FULL = LVL_W'(RING_DEPTH);

   // operation codes carried on req_tuser
   typedef enum logic [2:0] {
      OP_TX_PUT   = 3'd0,
      OP_TX_DRAIN = 3'd1,
      OP_RX_RECV  = 3'd2,
      OP_RX_GET   = 3'd3,
      OP_RX_FLUSH = 3'd4,
      OP_TX_FLUSH = 3'd5
   } op_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // wrap a ring position
   function automatic ptr_type next_pos(input ptr_type p);
      ptr_type n;
      n = (p == PTR_LAST) ? '0 : p + 1'b1;
      return n;
   endfunction

endpackage

`default_nettype wire

// File: design/uart_dual_ring_buffer.sv
// uart_dual_ring_buffer: transmit and receive byte rings between software and a uart
// each ring is a one-port-write, one-port-read synchronous memory; uses udrb_pkg
//
// Each request transaction carries an operation on req_tuser (tx put, tx drain, rx receive,
// rx get, flush rx, flush tx) and a byte on req_tdata, and yields exactly one response
// transaction with the byte read (if any), a reject flag for a put on a full transmit ring,
// both fill levels and the transmit interrupt flag after the operation. Operations that read
// no byte load the response register directly; a drain or get that returns a byte first goes
// through the registered read of the ring memory and the read state. The response sits in an
// output register, so a new request is taken in the cycle the previous response leaves. A full
// receive ring drops its oldest byte on a receive. Each ring holds eight bytes.
`default_nettype none

module uart_dual_ring_buffer (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_in
   input  wire  [2:0]  req_tuser,   // [2:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_out, [8] put_rejected, [12:9] tx_level,
                                    // [16:13] rx_level, [17] tx_irq_armed, rest zero
   output logic        rsp_tuser    // [0] data_valid
);

   // ring control registers
   udrb_pkg::ptr_type   tx_rd_pos_ff, tx_rd_pos_in, tx_wr_pos_ff, tx_wr_pos_in;
   udrb_pkg::ptr_type   rx_rd_pos_ff, rx_rd_pos_in, rx_wr_pos_ff, rx_wr_pos_in;
   udrb_pkg::lvl_type   tx_fill_ff, tx_fill_in, rx_fill_ff, rx_fill_in;
   logic                irq_ff, irq_in;
   udrb_pkg::state_type state_ff, state_in;
   logic                sel_rx_ff, sel_rx_in;

   // ring memories and their read data
   udrb_pkg::byte_type  tx_mem_ff [udrb_pkg::RING_DEPTH];
   udrb_pkg::byte_type  rx_mem_ff [udrb_pkg::RING_DEPTH];
   udrb_pkg::byte_type  tx_rdata_ff, rx_rdata_ff;
   logic                tx_we, tx_re, rx_we, rx_re;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   udrb_pkg::byte_type  rsp_data_ff, rsp_data_in;
   logic                rsp_dvalid_ff, rsp_dvalid_in;
   logic                rsp_rej_ff, rsp_rej_in;
   udrb_pkg::lvl_type   rsp_tx_lvl_ff, rsp_tx_lvl_in, rsp_rx_lvl_ff, rsp_rx_lvl_in;
   logic                rsp_irq_ff, rsp_irq_in;

   logic                req_fire;
   udrb_pkg::op_type    op;
   udrb_pkg::byte_type  din;
   logic                rej;

   assign op  = udrb_pkg::op_type'(req_tuser);
   assign din = req_tdata;

   // take a request only when idle and the response register is free or draining
   assign req_tready = (state_ff == udrb_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // next-state and ring update logic
   always_comb begin
      tx_rd_pos_in  = tx_rd_pos_ff;
      tx_wr_pos_in  = tx_wr_pos_ff;
      tx_fill_in    = tx_fill_ff;
      rx_rd_pos_in  = rx_rd_pos_ff;
      rx_wr_pos_in  = rx_wr_pos_ff;
      rx_fill_in    = rx_fill_ff;
      irq_in        = irq_ff;
      state_in      = state_ff;
      sel_rx_in     = sel_rx_ff;
      tx_we         = 1'b0;
      tx_re         = 1'b0;
      rx_we         = 1'b0;
      rx_re         = 1'b0;
      rej           = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_dvalid_in = rsp_dvalid_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_tx_lvl_in = rsp_tx_lvl_ff;
      rsp_rx_lvl_in = rsp_rx_lvl_ff;
      rsp_irq_in    = rsp_irq_ff;

      case (state_ff)
         udrb_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (op)
                  udrb_pkg::OP_TX_PUT: begin
                     if (tx_fill_ff == udrb_pkg::RING_FULL) begin
                        rej = 1'b1;
                     end else begin
                        tx_we        = 1'b1;
                        tx_wr_pos_in = udrb_pkg::next_pos(tx_wr_pos_ff);
                        tx_fill_in   = tx_fill_ff + 1'b1;
                     end
                     irq_in = 1'b1;
                  end
                  udrb_pkg::OP_TX_DRAIN: begin
                     if (tx_fill_ff != '0) begin
                        tx_re        = 1'b1;
                        tx_rd_pos_in = udrb_pkg::next_pos(tx_rd_pos_ff);
                        tx_fill_in   = tx_fill_ff - 1'b1;
                     end
                     if (tx_fill_in == '0) begin
                        irq_in = 1'b0;
                     end
                  end
                  udrb_pkg::OP_RX_RECV: begin
                     rx_we        = 1'b1;
                     rx_wr_pos_in = udrb_pkg::next_pos(rx_wr_pos_ff);
                     if (rx_fill_ff != udrb_pkg::RING_FULL) begin
                        rx_fill_in = rx_fill_ff + 1'b1;
                     end else begin
                        // overwrite oldest byte
                        rx_rd_pos_in = udrb_pkg::next_pos(rx_rd_pos_ff);
                     end
                  end
                  udrb_pkg::OP_RX_GET: begin
                     if (rx_fill_ff != '0) begin
                        rx_re        = 1'b1;
                        rx_rd_pos_in = udrb_pkg::next_pos(rx_rd_pos_ff);
                        rx_fill_in   = rx_fill_ff - 1'b1;
                     end
                  end
                  udrb_pkg::OP_RX_FLUSH: begin
                     rx_rd_pos_in = '0;
                     rx_wr_pos_in = '0;
                     rx_fill_in   = '0;
                  end
                  udrb_pkg::OP_TX_FLUSH: begin
                     tx_rd_pos_in = '0;
                     tx_wr_pos_in = '0;
                     tx_fill_in   = '0;
                  end
                  default: begin
                  end
               endcase

               // capture status now; a memory read completes it next cycle
               rsp_data_in   = '0;
               rsp_dvalid_in = 1'b0;
               rsp_rej_in    = rej;
               rsp_tx_lvl_in = tx_fill_in;
               rsp_rx_lvl_in = rx_fill_in;
               rsp_irq_in    = irq_in;
               if (tx_re || rx_re) begin
                  state_in  = udrb_pkg::ST_READ;
                  sel_rx_in = rx_re;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         udrb_pkg::ST_READ: begin
            // read data is ready; response register is empty here
            rsp_data_in   = sel_rx_ff ? rx_rdata_ff : tx_rdata_ff;
            rsp_dvalid_in = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = udrb_pkg::ST_IDLE;
         end
         default: begin
            state_in = udrb_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_rd_pos_ff <= '0;
         tx_wr_pos_ff <= '0;
         tx_fill_ff   <= '0;
         rx_rd_pos_ff <= '0;
         rx_wr_pos_ff <= '0;
         rx_fill_ff   <= '0;
         irq_ff       <= 1'b0;
         state_ff     <= udrb_pkg::ST_IDLE;
         sel_rx_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_rd_pos_ff <= tx_rd_pos_in;
         tx_wr_pos_ff <= tx_wr_pos_in;
         tx_fill_ff   <= tx_fill_in;
         rx_rd_pos_ff <= rx_rd_pos_in;
         rx_wr_pos_ff <= rx_wr_pos_in;
         rx_fill_ff   <= rx_fill_in;
         irq_ff       <= irq_in;
         state_ff     <= state_in;
         sel_rx_ff    <= sel_rx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_tx_lvl_ff <= rsp_tx_lvl_in;
      rsp_rx_lvl_ff <= rsp_rx_lvl_in;
      rsp_irq_ff    <= rsp_irq_in;
   end

   // transmit ring memory
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem_ff[tx_wr_pos_ff] <= din;
      end
      if (tx_re) begin
         tx_rdata_ff <= tx_mem_ff[tx_rd_pos_ff];
      end
   end

   // receive ring memory
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem_ff[rx_wr_pos_ff] <= din;
      end
      if (rx_re) begin
         rx_rdata_ff <= rx_mem_ff[rx_rd_pos_ff];
      end
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_dvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_irq_ff, rsp_rx_lvl_ff, rsp_tx_lvl_ff, rsp_rej_ff, rsp_data_ff};

endmodule

`default_nettype wire
